FILE: rtl/clst_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clst_pkg
// shared types, request codes and sizes of the cursor list store
// ---------------------------------------------------------------------------
package clst_pkg;

  // fixed field widths of the request and result channels
  localparam int OP_W       = 4;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = 6;
  localparam int STATUS_W   = 2;
  localparam int MAX_WORD_W = 64;

  // defaults for the top-level parameters
  localparam int DEF_DEPTH      = 64;
  localparam int DEF_WORD_WIDTH = 32;

  // request codes
  localparam logic [OP_W-1:0] OP_START     = 4'd0;
  localparam logic [OP_W-1:0] OP_END       = 4'd1;
  localparam logic [OP_W-1:0] OP_ADVANCE   = 4'd2;
  localparam logic [OP_W-1:0] OP_RETREAT   = 4'd3;
  localparam logic [OP_W-1:0] OP_INSERT    = 4'd4;
  localparam logic [OP_W-1:0] OP_ATTACH    = 4'd5;
  localparam logic [OP_W-1:0] OP_REMOVE    = 4'd6;
  localparam logic [OP_W-1:0] OP_FRONT_INS = 4'd7;
  localparam logic [OP_W-1:0] OP_BACK_APP  = 4'd8;
  localparam logic [OP_W-1:0] OP_REM_FRONT = 4'd9;
  localparam logic [OP_W-1:0] OP_READ_IDX  = 4'd10;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NONE  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

  // chain operation codes
  localparam logic [1:0] MODE_HOLD = 2'd0;
  localparam logic [1:0] MODE_INS  = 2'd1;
  localparam logic [1:0] MODE_DEL  = 2'd2;

  // per-cell control
  typedef struct packed {
    logic load;        // take the new word
    logic from_left;   // take the lower neighbor's word
    logic from_right;  // take the upper neighbor's word
  } clst_cell_ctl_t;

endpackage

FILE: rtl/clst_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clst_req_if
// request channel of the cursor list store
// ---------------------------------------------------------------------------
interface clst_req_if
  import clst_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [DATA_W-1:0] value;
  logic [IDX_W-1:0]  index;

  modport source (output valid, output op, output value, output index, input ready);
  modport sink   (input valid, input op, input value, input index, output ready);
endinterface

FILE: rtl/clst_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clst_rsp_if
// result channel of the cursor list store
// ---------------------------------------------------------------------------
interface clst_rsp_if
  import clst_pkg::*;
#(
  parameter int CNT_W = $clog2(DEF_DEPTH + 1)
);
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   read_value;
  logic [CNT_W-1:0]    item_count;
  logic [CNT_W-1:0]    cursor_pos;
  logic                has_current;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output read_value, output item_count, output cursor_pos,
                  output has_current, output status, input ready);
  modport sink   (input valid, input read_value, input item_count, input cursor_pos,
                  input has_current, input status, output ready);
endinterface

FILE: rtl/clst_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clst_cell
// one list slot: loads, shifts from a neighbor or holds
// ---------------------------------------------------------------------------
module clst_cell
  import clst_pkg::*;
#(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
  input  logic                  clk,
  input  clst_cell_ctl_t        ctl,
  input  logic [WORD_WIDTH-1:0] wdata,
  input  logic [WORD_WIDTH-1:0] left_word,
  input  logic [WORD_WIDTH-1:0] right_word,
  output logic [WORD_WIDTH-1:0] word
);

  logic [WORD_WIDTH-1:0] word_r;
  logic [WORD_WIDTH-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctl.load) begin
      word_nxt = wdata;
    end else if (ctl.from_left) begin
      word_nxt = left_word;
    end else if (ctl.from_right) begin
      word_nxt = right_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

FILE: rtl/clst_chain.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clst_chain
// row of list cells with per-cell shift control and an indexed read
// ---------------------------------------------------------------------------
module clst_chain
  import clst_pkg::*;
#(
  parameter int DEPTH      = DEF_DEPTH,
  parameter int WORD_WIDTH = DEF_WORD_WIDTH,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic [1:0]            mode,
  input  logic [AW-1:0]         pos,
  input  logic [WORD_WIDTH-1:0] wdata,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [WORD_WIDTH-1:0] rd_word
);

  logic [WORD_WIDTH-1:0] words [DEPTH];
  clst_cell_ctl_t        ctl   [DEPTH];

  // insert: slot at pos loads, slots above take from below
  // delete: slots from pos upward take from above
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].load       = (mode == MODE_INS) && (AW'(i) == pos);
      ctl[i].from_left  = (mode == MODE_INS) && (AW'(i) > pos);
      ctl[i].from_right = (mode == MODE_DEL) && (AW'(i) >= pos);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_w;
    logic [WORD_WIDTH-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[g+1];
    end
    clst_cell #(.WORD_WIDTH(WORD_WIDTH)) u_cell (
      .clk        (clk),
      .ctl        (ctl[g]),
      .wdata      (wdata),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[g])
    );
  end

  // read gather: each slot drives only on an address match
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (rd_en && (AW'(i) == rd_addr)) begin
        rd_word = rd_word | words[i];
      end
    end
  end

endmodule

FILE: rtl/cursor_list_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cursor_list_store
// fixed-capacity ordered word list with a cursor
// ---------------------------------------------------------------------------
// An ordered list of up to DEPTH words with a cursor. Each request moves the
// cursor, inserts or removes a word, or reads the word at an index, and gives
// exactly one result with status, count, cursor, a current-item flag and the
// read word (the word at the index for a read, else the current word, else
// zero). The words live in a row of cells; an insert or remove shifts every
// cell above the position by one slot in the update step. A request passes
// through the step in which it is taken, an update of the cell row and
// cursor/count, then a read of the row that fills the output register. The
// next request is taken as soon as the result sits in the output register,
// even while that result still waits to be taken. No request is taken during
// reset. The word store needs no clearing after reset: only slots below the
// count are read.
// ---------------------------------------------------------------------------
module cursor_list_store
  import clst_pkg::*;
#(
  parameter int DEPTH      = DEF_DEPTH,
  parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  clst_req_if.sink          in_ch,
  clst_rsp_if.source        out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state_r, state_nxt;

  // captured request
  logic [OP_W-1:0]   op_r;
  logic [DATA_W-1:0] val_r;
  logic [IDX_W-1:0]  idx_r;

  // list state
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cur_r, cur_nxt;

  // values carried from the update step to the read step
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                rd_en_r, rd_en_nxt;
  logic [AW-1:0]       rd_addr_r, rd_addr_nxt;

  // output register
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_value_r;
  logic [CW-1:0]       out_count_r;
  logic [CW-1:0]       out_cursor_r;
  logic                out_hascur_r;
  logic [STATUS_W-1:0] out_status_r;

  // chain control
  logic [1:0]            mode;
  logic [AW-1:0]         pos;
  logic [WORD_WIDTH-1:0] wdata;
  logic [WORD_WIDTH-1:0] rd_word;

  logic [MAX_WORD_W-1:0] val_x;
  logic [MAX_WORD_W-1:0] rd_x;
  logic [XW-1:0]         idx_x;
  logic [XW-1:0]         count_x;
  logic                  full;
  logic                  cur_ok;
  logic                  did_read;
  logic                  in_take;
  logic                  out_load;

  assign in_take  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = rst_n && (state_r == S_IDLE);

  // result may enter the output register once the old one is gone
  assign out_load = (state_r == S_READ) && (!out_valid_r || out_ch.ready);

  // new word trimmed or zero-extended to the stored width
  assign val_x = MAX_WORD_W'(val_r);
  assign wdata = val_x[WORD_WIDTH-1:0];

  assign idx_x   = XW'(idx_r);
  assign count_x = XW'(count_r);

  assign full   = (count_r == CW'(DEPTH));
  assign cur_ok = (cur_r < count_r);

  // request decode, evaluated in the update step
  always_comb begin
    count_nxt  = count_r;
    cur_nxt    = cur_r;
    status_nxt = STAT_OK;
    mode       = MODE_HOLD;
    pos        = '0;
    did_read   = 1'b0;
    if (state_r == S_EXEC) begin
      unique case (op_r)
        OP_START: begin
          cur_nxt = '0;
        end
        OP_END: begin
          cur_nxt = (count_r != '0) ? count_r - CW'(1) : '0;
        end
        OP_ADVANCE: begin
          if (!cur_ok) status_nxt = STAT_NONE;
          else cur_nxt = cur_r + CW'(1);
        end
        OP_RETREAT: begin
          if (cur_r != '0) cur_nxt = cur_r - CW'(1);
        end
        OP_INSERT: begin
          if (full) begin
            status_nxt = STAT_FULL;
          end else begin
            mode      = MODE_INS;
            pos       = cur_ok ? cur_r[AW-1:0] : count_r[AW-1:0];
            count_nxt = count_r + CW'(1);
          end
        end
        OP_ATTACH: begin
          if (full) begin
            status_nxt = STAT_FULL;
          end else if (!cur_ok) begin
            // append; cursor now lands on the new word
            mode      = MODE_INS;
            pos       = count_r[AW-1:0];
            count_nxt = count_r + CW'(1);
          end else begin
            mode      = MODE_INS;
            cur_nxt   = cur_r + CW'(1);
            pos       = cur_nxt[AW-1:0];
            count_nxt = count_r + CW'(1);
          end
        end
        OP_REMOVE: begin
          if (!cur_ok) begin
            status_nxt = STAT_NONE;
          end else begin
            mode      = MODE_DEL;
            pos       = cur_r[AW-1:0];
            count_nxt = count_r - CW'(1);
          end
        end
        OP_FRONT_INS: begin
          if (full) begin
            status_nxt = STAT_FULL;
          end else begin
            mode      = MODE_INS;
            cur_nxt   = '0;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_BACK_APP: begin
          if (full) begin
            status_nxt = STAT_FULL;
          end else begin
            mode      = MODE_INS;
            pos       = count_r[AW-1:0];
            count_nxt = count_r + CW'(1);
          end
        end
        OP_REM_FRONT: begin
          if (!cur_ok) begin
            status_nxt = STAT_NONE;
          end else begin
            mode      = MODE_DEL;
            count_nxt = count_r - CW'(1);
          end
        end
        OP_READ_IDX: begin
          if (idx_x >= count_x) status_nxt = STAT_RANGE;
          else did_read = 1'b1;
        end
        default: begin
          // unused codes leave everything as is
        end
      endcase
    end
  end

  // read address for the result word, taken after the update
  always_comb begin
    rd_en_nxt   = did_read || (cur_nxt < count_nxt);
    rd_addr_nxt = did_read ? idx_x[AW-1:0] : cur_nxt[AW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_take) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_READ;
      S_READ:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EXEC) begin
        count_r <= count_nxt;
        cur_r   <= cur_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r  <= in_ch.op;
      val_r <= in_ch.value;
      idx_r <= in_ch.index;
    end
    if (state_r == S_EXEC) begin
      status_r  <= status_nxt;
      rd_en_r   <= rd_en_nxt;
      rd_addr_r <= rd_addr_nxt;
    end
    if (out_load) begin
      out_value_r  <= rd_x[DATA_W-1:0];
      out_count_r  <= count_r;
      out_cursor_r <= cur_r;
      out_hascur_r <= (cur_r < count_r);
      out_status_r <= status_r;
    end
  end

  // stored word widened to the result field
  always_comb begin
    rd_x = '0;
    rd_x[WORD_WIDTH-1:0] = rd_word;
  end

  clst_chain #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_chain (
    .clk     (clk),
    .mode    (mode),
    .pos     (pos),
    .wdata   (wdata),
    .rd_en   (rd_en_r),
    .rd_addr (rd_addr_r),
    .rd_word (rd_word)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_value  = out_value_r;
  assign out_ch.item_count  = out_count_r;
  assign out_ch.cursor_pos  = out_cursor_r;
  assign out_ch.has_current = out_hascur_r;
  assign out_ch.status      = out_status_r;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the cursor list store
// ---------------------------------------------------------------------------
// Sends requests over the request channel and checks every result against a
// shadow copy of the list (words, count and cursor) that is kept up to date
// as each request is accepted. A short directed run covers the empty list,
// the end-of-list cursor and the unused codes. Random fill, drain and mixed
// stretches follow. They push the list to full and back to empty. Both
// channels stall at random in the first two of three rounds.
// ---------------------------------------------------------------------------
module testbench;
  import clst_pkg::*;

  localparam int LIST_DEPTH  = DEF_DEPTH;
  localparam int CNT_W       = $clog2(DEF_DEPTH + 1);
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 20;
  localparam int ROUND_LEN   = 560;

  // codes above read-index do nothing and answer ok
  localparam logic [OP_W-1:0] FIRST_SPARE_OP = OP_READ_IDX + 1'b1;
  localparam logic [OP_W-1:0] LAST_SPARE_OP  = {OP_W{1'b1}};

  typedef struct {
    logic [DATA_W-1:0]   read_value;
    logic [CNT_W-1:0]    item_count;
    logic [CNT_W-1:0]    cursor_pos;
    logic                has_current;
    logic [STATUS_W-1:0] status;
  } list_result_t;

  // stimulus bias for the random part
  typedef enum {MOOD_FILL, MOOD_DRAIN, MOOD_CHURN} mood_t;

  // -------------------------------------------------------------------------
  // shadow of the list: updated on every accepted request, queues the result
  // that request must produce
  // -------------------------------------------------------------------------
  class list_shadow;
    logic [DATA_W-1:0] words [LIST_DEPTH];
    logic [CNT_W-1:0]  word_count;
    logic [CNT_W-1:0]  cursor;
    list_result_t      expected_q[$];
    int                checked;
    int                failures;
    int                status_seen[4];

    function new();
      word_count = '0;
      cursor     = '0;
      checked    = 0;
      failures   = 0;
      foreach (words[i]) words[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // open a slot at pos, later words move up
    function void shift_in(logic [CNT_W-1:0] pos, logic [DATA_W-1:0] v);
      for (int i = int'(word_count); i > int'(pos); i--) words[i] = words[i-1];
      words[pos] = v;
      word_count++;
    endfunction

    // close the slot at pos, later words move down
    function void shift_out(logic [CNT_W-1:0] pos);
      for (int i = int'(pos) + 1; i < int'(word_count); i++) words[i-1] = words[i];
      word_count--;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] value,
                               logic [IDX_W-1:0] index);
      list_result_t r;
      logic         has_room;
      logic         on_word;
      logic         read_done;
      has_room     = word_count < LIST_DEPTH;
      on_word      = cursor < word_count;
      read_done    = 1'b0;
      r.status     = STAT_OK;
      r.read_value = '0;
      case (op)
        OP_START: cursor = '0;
        OP_END: cursor = (word_count != 0) ? word_count - 1'b1 : '0;
        OP_ADVANCE: begin
          if (!on_word) r.status = STAT_NONE;
          else cursor++;
        end
        OP_RETREAT: begin
          if (cursor != 0) cursor--;
        end
        OP_INSERT: begin
          if (!has_room) r.status = STAT_FULL;
          else shift_in(on_word ? cursor : word_count, value);
        end
        OP_ATTACH: begin
          if (!has_room) r.status = STAT_FULL;
          else if (!on_word) shift_in(word_count, value);
          else begin
            shift_in(cursor + 1'b1, value);
            cursor++;
          end
        end
        OP_REMOVE: begin
          if (!on_word) r.status = STAT_NONE;
          else shift_out(cursor);
        end
        OP_FRONT_INS: begin
          if (!has_room) r.status = STAT_FULL;
          else begin
            shift_in('0, value);
            cursor = '0;
          end
        end
        OP_BACK_APP: begin
          if (!has_room) r.status = STAT_FULL;
          else shift_in(word_count, value);
        end
        OP_REM_FRONT: begin
          if (!on_word) r.status = STAT_NONE;
          else shift_out('0);
        end
        OP_READ_IDX: begin
          if (index >= word_count) r.status = STAT_RANGE;
          else begin
            r.read_value = words[index];
            read_done    = 1'b1;
          end
        end
        default: ;
      endcase
      if (!read_done && cursor < word_count) r.read_value = words[cursor[IDX_W-1:0]];
      r.item_count  = word_count;
      r.cursor_pos  = cursor;
      r.has_current = cursor < word_count;
      expected_q.push_back(r);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with nothing pending: count %0d cursor %0d status %0d",
               got.item_count, got.cursor_pos, got.status);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      status_seen[want.status]++;
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0h, got %0h", want.read_value, got.read_value);
        failures++;
      end
      if (got.item_count !== want.item_count) begin
        $error("item_count: expected %0d, got %0d", want.item_count, got.item_count);
        failures++;
      end
      if (got.cursor_pos !== want.cursor_pos) begin
        $error("cursor_pos: expected %0d, got %0d", want.cursor_pos, got.cursor_pos);
        failures++;
      end
      if (got.has_current !== want.has_current) begin
        $error("has_current: expected %0b, got %0b", want.has_current, got.has_current);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // clock, reset, channels and the block
  // -------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  clst_req_if                req_if ();
  clst_rsp_if #(.CNT_W(CNT_W)) rsp_if ();

  cursor_list_store dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if.sink),
    .out_ch (rsp_if.source)
  );

  list_shadow shadow = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent          = 0;
  int cycle_count   = 0;

  // every input known from time zero
  initial begin
    req_if.valid = 1'b0;
    req_if.op    = OP_START;
    req_if.value = '0;
    req_if.index = '0;
    rsp_if.ready = 1'b0;
  end

  // result side: ready drawn each falling edge, held low through reset
  initial begin
    forever begin
      @(negedge clk);
      rsp_if.ready = rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // every taken result goes to the scoreboard
  always @(posedge clk) begin
    list_result_t got;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.read_value  = rsp_if.read_value;
      got.item_count  = rsp_if.item_count;
      got.cursor_pos  = rsp_if.cursor_pos;
      got.has_current = rsp_if.has_current;
      got.status      = rsp_if.status;
      shadow.check_result(got);
    end
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, shadow.expected_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // request driver: called at a falling edge, returns at the falling edge
  // after the request was taken
  // -------------------------------------------------------------------------
  task automatic send_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] value,
                              logic [IDX_W-1:0] index);
    // random gap before the request; valid only drops here, never in the
    // same step that raises it
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.op    = op;
    req_if.value = value;
    req_if.index = index;
    do @(posedge clk); while (!req_if.ready);
    shadow.note_request(op, value, index);
    sent++;
    @(negedge clk);
  endtask

  // data words lean toward the extremes now and then
  function automatic logic [DATA_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return '1;
    return $urandom;
  endfunction

  // index mostly inside the list, sometimes anywhere
  function automatic logic [IDX_W-1:0] pick_index();
    if (shadow.word_count != 0 && $urandom_range(99) < 80)
      return IDX_W'($urandom_range(int'(shadow.word_count) - 1));
    return IDX_W'($urandom_range(LIST_DEPTH - 1));
  endfunction

  function automatic logic [OP_W-1:0] pick_op(mood_t mood);
    logic [OP_W-1:0] grow_ops [4];
    logic [OP_W-1:0] shrink_ops [3];
    int              roll;
    grow_ops   = '{OP_INSERT, OP_ATTACH, OP_FRONT_INS, OP_BACK_APP};
    // removals need a current item, so the cursor gets pulled back often
    shrink_ops = '{OP_REMOVE, OP_REM_FRONT, OP_START};
    roll = $urandom_range(99);
    if (roll < 2) return OP_W'($urandom_range(LAST_SPARE_OP, FIRST_SPARE_OP));
    case (mood)
      MOOD_FILL:  if (roll < 65) return grow_ops[$urandom_range(3)];
      MOOD_DRAIN: if (roll < 65) return shrink_ops[$urandom_range(2)];
      default: ;
    endcase
    return OP_W'($urandom_range(OP_READ_IDX));
  endfunction

  // random stretches that fill the list up to full, drain it back to empty
  // or stir it in place
  task automatic random_requests(int count);
    mood_t mood;
    int    left_in_mood;
    mood         = MOOD_FILL;
    left_in_mood = 0;
    for (int i = 0; i < count; i++) begin
      if (left_in_mood == 0) begin
        case ($urandom_range(2))
          0:       mood = MOOD_FILL;
          1:       mood = MOOD_DRAIN;
          default: mood = MOOD_CHURN;
        endcase
        left_in_mood = $urandom_range(100, 20);
      end
      left_in_mood--;
      send_request(pick_op(mood), pick_word(), pick_index());
    end
  endtask

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // empty list: cursor moves, removals and reads all have nothing to act on
    send_request(OP_START,     '0, '0);
    send_request(OP_END,       '0, '0);   // cursor stays at 0 on an empty list
    send_request(OP_ADVANCE,   '0, '0);
    send_request(OP_RETREAT,   '0, '0);
    send_request(OP_REMOVE,    '0, '0);
    send_request(OP_REM_FRONT, '0, '0);
    send_request(OP_READ_IDX,  '0, '0);
    // first words: insert with no current item lands at the end
    send_request(OP_INSERT,    '0, '0);
    send_request(OP_ATTACH,    '1, '0);
    send_request(OP_FRONT_INS, 32'h5a5a_5a5a, '0);   // count rises by one only
    send_request(OP_BACK_APP,  32'ha5a5_a5a5, '0);
    send_request(OP_END,       '0, '0);
    send_request(OP_ADVANCE,   '0, '0);
    // past the end: attach appends and the cursor now sits on the new word
    send_request(OP_ATTACH,    32'h0000_0001, '0);
    send_request(OP_ADVANCE,   '0, '0);
    send_request(OP_INSERT,    32'h8000_0000, '0);
    send_request(OP_READ_IDX,  '0, '1);
    send_request(OP_READ_IDX,  '0, '0);
    send_request(OP_RETREAT,   '0, '0);
    send_request(OP_REMOVE,    '0, '0);
    send_request(OP_REM_FRONT, '0, '0);
    send_request(FIRST_SPARE_OP, '1, '1);
    send_request(LAST_SPARE_OP,  '1, '1);

    // sender stalls less than the receiver, then the other way round,
    // then both run flat out
    send_idle_pct = 38;
    recv_idle_pct = 64;
    random_requests(ROUND_LEN);
    send_idle_pct = 64;
    recv_idle_pct = 38;
    random_requests(ROUND_LEN);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_requests(ROUND_LEN);
    req_if.valid = 1'b0;

    // let the pipeline empty, then watch for stray results
    while (shadow.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d requests over three stall rounds, %0d results checked",
             sent, shadow.checked);
    $display("status mix: ok %0d, full %0d, no current %0d, out of range %0d",
             shadow.status_seen[STAT_OK], shadow.status_seen[STAT_FULL],
             shadow.status_seen[STAT_NONE], shadow.status_seen[STAT_RANGE]);
    if (shadow.failures == 0 && shadow.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
